// File: rtl/dbg_pkg.sv
// ----------------------------------------------------------------------------
// dbg_pkg - decompression budget guard package
// Opcodes, status codes, register indexes, reset values and shared records.
// ----------------------------------------------------------------------------
package dbg_pkg;

    localparam int OP_W      = 3;
    localparam int ST_W      = 3;
    localparam int DATA_W    = 64;
    localparam int WORD_W    = 32;
    localparam int DEPTH_W   = 8;
    localparam int CFG_IDX_W = 3;

    localparam int Q_DEPTH   = 8;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_CHARGE_OUT   = 3'd0,
        OP_CHARGE_ENTRY = 3'd1,
        OP_CHARGE_ITER  = 3'd2,
        OP_ENTER        = 3'd3,
        OP_LEAVE        = 3'd4,
        OP_CHECK_DECL   = 3'd5,
        OP_CLEAR        = 3'd6,
        OP_NOP          = 3'd7
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK         = 3'd0,
        ST_OUTPUT_CAP = 3'd1,
        ST_RATIO      = 3'd2,
        ST_ENTRIES    = 3'd3,
        ST_ITERATIONS = 3'd4,
        ST_DEPTH      = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTPUT_CAP      = 3'd0,
        CFG_RATIO_LIMIT     = 3'd1,
        CFG_RATIO_GRACE     = 3'd2,
        CFG_ENTRY_LIMIT     = 3'd3,
        CFG_ITERATION_LIMIT = 3'd4,
        CFG_DEPTH_LIMIT     = 3'd5
    } t_cfg_idx;

    localparam logic [DATA_W-1:0]  RST_OUTPUT_CAP      = 64'd268435456;
    localparam logic [WORD_W-1:0]  RST_RATIO_LIMIT     = 32'd100;
    localparam logic [WORD_W-1:0]  RST_RATIO_GRACE     = 32'd1048576;
    localparam logic [WORD_W-1:0]  RST_ENTRY_LIMIT     = 32'd65535;
    localparam logic [WORD_W-1:0]  RST_ITERATION_LIMIT = 32'd1000000;
    localparam logic [DEPTH_W-1:0] RST_DEPTH_LIMIT     = 8'd8;

    typedef struct packed {
        logic [DATA_W-1:0]  output_cap;
        logic [WORD_W-1:0]  ratio_limit;
        logic [WORD_W-1:0]  ratio_grace;
        logic [WORD_W-1:0]  entry_limit;
        logic [WORD_W-1:0]  iteration_limit;
        logic [DEPTH_W-1:0] depth_limit;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] comp;
        logic [DATA_W-1:0] amt;
        logic [DATA_W-1:0] bound;
    } t_cmd;

endpackage

// File: rtl/dbg_in_if.sv
// ----------------------------------------------------------------------------
// dbg_in_if - request channel
// Valid/ready channel carrying opcode, compressed total and amount.
// ----------------------------------------------------------------------------
interface dbg_in_if;
    import dbg_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [DATA_W-1:0] comp_total;
    logic [DATA_W-1:0] amount;

    modport source (output valid, output opcode, output comp_total, output amount, input ready);
    modport sink   (input valid, input opcode, input comp_total, input amount, output ready);

endinterface

// File: rtl/dbg_out_if.sv
// ----------------------------------------------------------------------------
// dbg_out_if - result channel
// Valid/ready channel carrying status and running output total.
// ----------------------------------------------------------------------------
interface dbg_out_if;
    import dbg_pkg::*;

    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] out_total;

    modport source (output valid, output status, output out_total, input ready);
    modport sink   (input valid, input status, input out_total, output ready);

endinterface

// File: rtl/dbg_front.sv
// ----------------------------------------------------------------------------
// dbg_front - request intake and ratio bound
// Accepts requests and computes the saturated ratio bound in two stages.
// ----------------------------------------------------------------------------
module dbg_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dbg_in_if.sink                        i_req,
    input  dbg_pkg::t_cfg                 i_cfg,
    input  logic [dbg_pkg::Q_CNT_W-1:0]   i_q_count,
    output logic                          o_push,
    output dbg_pkg::t_cmd                 o_cmd
);
    import dbg_pkg::*;

    logic                accept;
    logic [Q_CNT_W-1:0]  in_flight;
    logic [WORD_W:0]     mid;
    logic [DATA_W:0]     sum;

    logic                r_a_valid;
    t_op                 r_a_op;
    logic [DATA_W-1:0]   r_a_comp;
    logic [DATA_W-1:0]   r_a_amt;
    logic [DATA_W-1:0]   r_a_lo;
    logic [DATA_W-1:0]   r_a_hi;

    logic                r_b_valid;
    t_op                 r_b_op;
    logic [DATA_W-1:0]   r_b_comp;
    logic [DATA_W-1:0]   r_b_amt;
    logic [DATA_W-1:0]   r_b_prod;
    logic                r_b_ovf;

    // queue credit: everything in flight must find a slot
    assign in_flight   = i_q_count + Q_CNT_W'(r_a_valid) + Q_CNT_W'(r_b_valid);
    assign i_req.ready = in_flight < Q_CNT_W'(Q_DEPTH);
    assign accept      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
        end
        r_a_op   <= t_op'(i_req.opcode);
        r_a_comp <= i_req.comp_total;
        r_a_amt  <= i_req.amount;
        r_a_lo   <= DATA_W'(i_req.comp_total[WORD_W-1:0]) * DATA_W'(i_cfg.ratio_limit);
        r_a_hi   <= DATA_W'(i_req.comp_total[DATA_W-1:WORD_W]) * DATA_W'(i_cfg.ratio_limit);
        r_b_op   <= r_a_op;
        r_b_comp <= r_a_comp;
        r_b_amt  <= r_a_amt;
        r_b_prod <= {mid[WORD_W-1:0], r_a_lo[WORD_W-1:0]};
        r_b_ovf  <= (r_a_hi[DATA_W-1:WORD_W] != '0) || mid[WORD_W];
    end

    assign mid = {1'b0, r_a_hi[WORD_W-1:0]} + {1'b0, r_a_lo[DATA_W-1:WORD_W]};
    assign sum = {1'b0, r_b_prod} + (DATA_W+1)'(i_cfg.ratio_grace);

    assign o_push      = r_b_valid;
    assign o_cmd.op    = r_b_op;
    assign o_cmd.comp  = r_b_comp;
    assign o_cmd.amt   = r_b_amt;
    assign o_cmd.bound = (r_b_ovf || sum[DATA_W]) ? '1 : sum[DATA_W-1:0];

endmodule

// File: rtl/dbg_queue.sv
// ----------------------------------------------------------------------------
// dbg_queue - command queue
// Small register FIFO between intake and execution.
// ----------------------------------------------------------------------------
module dbg_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  dbg_pkg::t_cmd                 i_cmd,
    input  logic                          i_pop,
    output logic                          o_valid,
    output dbg_pkg::t_cmd                 o_cmd,
    output logic [dbg_pkg::Q_CNT_W-1:0]   o_count
);
    import dbg_pkg::*;

    t_cmd                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr;
    logic [Q_PTR_W-1:0]  r_rd;
    logic [Q_CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd];
    assign o_count = r_count;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < Q_CNT_W'(Q_DEPTH)) || i_pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue pop while empty");
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_rd == r_wr)
        else $error("queue pointers apart while empty");
`endif

endmodule

// File: rtl/dbg_back.sv
// ----------------------------------------------------------------------------
// dbg_back - budget counters
// Executes queued commands against the counters and registers the result.
// ----------------------------------------------------------------------------
module dbg_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dbg_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    input  dbg_pkg::t_cmd   i_cmd,
    output logic            o_pop,
    dbg_out_if.source       o_rsp
);
    import dbg_pkg::*;

    logic [DATA_W:0]      sum;
    logic [DATA_W-1:0]    sat_total;
    logic [DATA_W-1:0]    produced;
    logic                 cap_hit;
    logic                 ratio_hit;
    t_status              judged;

    logic [DATA_W-1:0]    r_output_count,     n_output_count;
    logic [DATA_W-1:0]    r_last_input_total, n_last_input_total;
    logic [WORD_W-1:0]    r_entry_count,      n_entry_count;
    logic [WORD_W-1:0]    r_iteration_count,  n_iteration_count;
    logic [DEPTH_W-1:0]   r_nest_depth,       n_nest_depth;
    logic                 r_out_valid,        n_out_valid;
    t_status              r_out_status,       n_out_status;
    logic [DATA_W-1:0]    r_out_total,        n_out_total;

    assign o_pop = i_valid && (!r_out_valid || o_rsp.ready);

    assign sum       = {1'b0, r_output_count} + {1'b0, i_cmd.amt};
    assign sat_total = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
    assign produced  = (i_cmd.op == OP_CHARGE_OUT) ? sat_total : i_cmd.amt;
    assign cap_hit   = produced > i_cfg.output_cap;
    assign ratio_hit = produced > i_cmd.bound;
    assign judged    = cap_hit ? ST_OUTPUT_CAP : (ratio_hit ? ST_RATIO : ST_OK);

    always_comb begin
        n_output_count     = r_output_count;
        n_last_input_total = r_last_input_total;
        n_entry_count      = r_entry_count;
        n_iteration_count  = r_iteration_count;
        n_nest_depth       = r_nest_depth;
        n_out_status       = r_out_status;
        n_out_total        = r_out_total;
        n_out_valid        = r_out_valid && !o_rsp.ready;
        if (o_pop) begin
            n_out_valid  = 1'b1;
            n_out_status = ST_OK;
            unique case (i_cmd.op)
                OP_CHARGE_OUT: begin
                    n_output_count     = sat_total;
                    n_last_input_total = i_cmd.comp;
                    n_out_status       = judged;
                end
                OP_CHARGE_ENTRY: begin
                    if (r_entry_count >= i_cfg.entry_limit) begin
                        n_out_status = ST_ENTRIES;
                    end else begin
                        n_entry_count = r_entry_count + 1'b1;
                    end
                end
                OP_CHARGE_ITER: begin
                    if (r_iteration_count >= i_cfg.iteration_limit) begin
                        n_out_status = ST_ITERATIONS;
                    end else begin
                        n_iteration_count = r_iteration_count + 1'b1;
                    end
                end
                OP_ENTER: begin
                    if (r_nest_depth >= i_cfg.depth_limit) begin
                        n_out_status = ST_DEPTH;
                    end else begin
                        n_nest_depth = r_nest_depth + 1'b1;
                    end
                end
                OP_LEAVE: begin
                    if (r_nest_depth != '0) begin
                        n_nest_depth = r_nest_depth - 1'b1;
                    end
                end
                OP_CHECK_DECL: begin
                    n_out_status = judged;
                end
                OP_CLEAR: begin
                    n_output_count     = '0;
                    n_last_input_total = '0;
                    n_entry_count      = '0;
                    n_iteration_count  = '0;
                    n_nest_depth       = '0;
                end
                default: begin
                end
            endcase
            n_out_total = n_output_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_count     <= '0;
            r_last_input_total <= '0;
            r_entry_count      <= '0;
            r_iteration_count  <= '0;
            r_nest_depth       <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            r_output_count     <= n_output_count;
            r_last_input_total <= n_last_input_total;
            r_entry_count      <= n_entry_count;
            r_iteration_count  <= n_iteration_count;
            r_nest_depth       <= n_nest_depth;
            r_out_valid        <= n_out_valid;
        end
        r_out_status <= n_out_status;
        r_out_total  <= n_out_total;
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.out_total = r_out_total;

`ifndef SYNTHESIS
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_cmd.op == OP_CLEAR |=> r_output_count == '0 && r_out_total == '0
            && r_out_status == ST_OK)
        else $error("clear left counters or result nonzero");
    a_total_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_cmd.op == OP_CHARGE_OUT |=> r_output_count >= $past(r_output_count)
            && r_out_total == r_output_count)
        else $error("output total decreased on charge");
    a_leave_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_cmd.op == OP_LEAVE && r_nest_depth == '0 |=>
            r_nest_depth == '0 && r_out_status == ST_OK)
        else $error("leave at depth zero changed depth or status");
`endif

endmodule

// File: rtl/decompression_budget_guard.sv
// ----------------------------------------------------------------------------
// decompression_budget_guard - decompressor budget guard
// Output, ratio, entry, iteration and nesting budgets checked per request.
//
//   channel   dir  handshake          payload
//   i_req     in   valid/ready        opcode, comp_total, amount
//   o_rsp     out  valid/ready        status, out_total
//   i_cfg_*   in   write enable only  i_cfg_idx, i_cfg_data
//
// One request per cycle while queue credit lasts and o_rsp is not stalled;
// result load path: two multiply stages, queue write, execute on queue read.
// The 32x32 partial products of the ratio bound set the intake depth.
// Synchronous active-low reset restores register defaults and zero counters.
// A stalled result holds; the 8-entry queue lets intake continue meanwhile.
// ----------------------------------------------------------------------------
module decompression_budget_guard (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dbg_in_if.sink                          i_req,
    dbg_out_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [dbg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dbg_pkg::DATA_W-1:0]      i_cfg_data
);
    import dbg_pkg::*;

    t_cfg                r_cfg;
    logic                push;
    logic                pop;
    logic                q_valid;
    t_cmd                push_cmd;
    t_cmd                q_cmd;
    logic [Q_CNT_W-1:0]  q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.output_cap      <= RST_OUTPUT_CAP;
            r_cfg.ratio_limit     <= RST_RATIO_LIMIT;
            r_cfg.ratio_grace     <= RST_RATIO_GRACE;
            r_cfg.entry_limit     <= RST_ENTRY_LIMIT;
            r_cfg.iteration_limit <= RST_ITERATION_LIMIT;
            r_cfg.depth_limit     <= RST_DEPTH_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OUTPUT_CAP:      r_cfg.output_cap      <= i_cfg_data;
                CFG_RATIO_LIMIT:     r_cfg.ratio_limit     <= i_cfg_data[WORD_W-1:0];
                CFG_RATIO_GRACE:     r_cfg.ratio_grace     <= i_cfg_data[WORD_W-1:0];
                CFG_ENTRY_LIMIT:     r_cfg.entry_limit     <= i_cfg_data[WORD_W-1:0];
                CFG_ITERATION_LIMIT: r_cfg.iteration_limit <= i_cfg_data[WORD_W-1:0];
                CFG_DEPTH_LIMIT:     r_cfg.depth_limit     <= i_cfg_data[DEPTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dbg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_cfg     (r_cfg),
        .i_q_count (q_count),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    dbg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .o_count (q_count)
    );

    dbg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule
